@@ sv/dijkstra_shortest_path_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the shortest path block
// Concurrent checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef DIJKSTRA_SHORTEST_PATH_TOP_MACROS_SVH
`define DIJKSTRA_SHORTEST_PATH_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define DSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DSP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `DSP_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define DSP_ASSERT(lbl, clk, rst_n, prop, msg)
`define DSP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ sv/dsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Shortest path package
// Field widths, codes, controller commands and the heap ordering.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int unsigned NUM_VERTICES_DEF = 64;
  localparam int unsigned NUM_EDGES_DEF    = 256;
  localparam int unsigned WEIGHT_BITS_DEF  = 16;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned VTX_W = 6;
  localparam int unsigned WIN_W = 16;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned LEN_W = 24;

  localparam logic [LEN_W-1:0] DIST_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NOPATH = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_ADD_RD, CMD_ADD_WR, CMD_CLEAR, CMD_Q_INIT,
    CMD_PUSH, CMD_SU_CHK, CMD_SU_CMP, CMD_POP_RD0, CMD_POP_RDL, CMD_POP_X,
    CMD_SD_CHK, CMD_SD_L, CMD_SD_R, CMD_SD_CMP, CMD_SETTLE, CMD_E_HEAD,
    CMD_E_RD, CMD_E_EVAL, CMD_E_RELAX, CMD_E_NEXT, CMD_FIN_RD, CMD_FIN_LEN,
    CMD_EMIT_OK, CMD_EMIT_FULL, CMD_EMIT_NOPATH, CMD_EMIT_PATH,
    CMD_PATH_NXT, CMD_EMIT_SRC
  } cmd_e;

  typedef struct packed {
    op_e  op;
    logic add_full;
    logic vtx_ok;
    logic heap_empty;
    logic heap_full;
    logic su_root;
    logic su_less;
    logic sd_leaf;
    logic sd_has_r;
    logic sd_stay;
    logic u_settled;
    logic u_is_t;
    logic e_null;
    logic w_skip;
    logic relax_do;
    logic t_reached;
    logic path_more;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [VTX_W-1:0] vtx;
  } heap_ent_t;

  function automatic logic heap_less(heap_ent_t a, heap_ent_t b);
    logic lt;
    if (a.len != b.len) begin
      lt = a.len < b.len;
    end else begin
      lt = a.vtx < b.vtx;
    end
    return lt;
  endfunction

endpackage

@@ sv/dsp_if.sv @@
// ----------------------------------------------------------------------------
// Shortest path stream interfaces
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface dsp_in_if;
  import dsp_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [VTX_W-1:0] src_vertex;
  logic [VTX_W-1:0] dst_vertex;
  logic [WIN_W-1:0] weight;
  modport source (output valid, opcode, src_vertex, dst_vertex, weight, input ready);
  modport sink   (input valid, opcode, src_vertex, dst_vertex, weight, output ready);
endinterface

interface dsp_out_if;
  import dsp_pkg::*;
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [VTX_W-1:0] path_vertex;
  logic [LEN_W-1:0] path_length;
  logic             last;
  modport source (output valid, status, path_vertex, path_length, last, input ready);
  modport sink   (input valid, status, path_vertex, path_length, last, output ready);
endinterface

@@ sv/dsp_datapath.sv @@
// ----------------------------------------------------------------------------
// Shortest path datapath
// Adjacency store, distance and predecessor stores, min-heap and result beat.
// ----------------------------------------------------------------------------
`include "dijkstra_shortest_path_top_macros.svh"

module dsp_datapath #(
  parameter int unsigned NUM_VERTICES = dsp_pkg::NUM_VERTICES_DEF,
  parameter int unsigned NUM_EDGES    = dsp_pkg::NUM_EDGES_DEF,
  parameter int unsigned WEIGHT_BITS  = dsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dsp_pkg::cmd_e             cmd_i,
  output dsp_pkg::sts_t             sts_o,
  input  logic [dsp_pkg::OP_W-1:0]  in_opcode_i,
  input  logic [dsp_pkg::VTX_W-1:0] in_src_i,
  input  logic [dsp_pkg::VTX_W-1:0] in_dst_i,
  input  logic [dsp_pkg::WIN_W-1:0] in_weight_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [dsp_pkg::ST_W-1:0]  out_status_o,
  output logic [dsp_pkg::VTX_W-1:0] out_vertex_o,
  output logic [dsp_pkg::LEN_W-1:0] out_length_o,
  output logic                      out_last_o
);
  import dsp_pkg::*;

  localparam int unsigned VW  = $clog2(NUM_VERTICES);
  localparam int unsigned EIW = (NUM_EDGES > 1) ? $clog2(NUM_EDGES) : 1;
  localparam int unsigned ENW = $clog2(NUM_EDGES + 1);
  localparam int unsigned HD  = NUM_EDGES + 1;
  localparam int unsigned HIW = $clog2(HD);
  localparam int unsigned HCW = $clog2(HD + 1);
  localparam int unsigned SW  = ((LEN_W > WEIGHT_BITS) ? LEN_W : WEIGHT_BITS) + 1;
  localparam logic [ENW-1:0]   E_NULL = ENW'(NUM_EDGES);
  localparam logic [HCW-1:0]   H_CAP  = HCW'(HD);
  localparam logic [VTX_W:0]   V_LIM  = (VTX_W + 1)'(NUM_VERTICES);
  localparam logic [VW:0]      N_LIM  = (VW + 1)'(NUM_VERTICES);

  typedef struct packed {
    logic [VTX_W-1:0]       tgt;
    logic [WEIGHT_BITS-1:0] wgt;
    logic [ENW-1:0]         nxt;
  } edge_t;

  // memories
  edge_t            edge_mem [NUM_EDGES];
  logic [ENW-1:0]   lh_mem   [NUM_VERTICES];
  logic [LEN_W-1:0] dist_mem [NUM_VERTICES];
  logic [VTX_W-1:0] pred_mem [NUM_VERTICES];
  heap_ent_t        heap_mem [HD];

  edge_t            edge_rd_q;
  logic [ENW-1:0]   lh_rd_q;
  logic             lh_vld_rd_q;
  logic [LEN_W-1:0] dist_rd_q;
  logic [VTX_W-1:0] pred_rd_q;
  heap_ent_t        heap_rd_q;

  // control state
  logic [NUM_VERTICES-1:0] lh_vld_q, reached_q, settled_q;
  logic [ENW-1:0]          ecnt_q;
  logic [HCW-1:0]          hcnt_q;
  logic                    out_vld_q;

  // payload registers
  op_e                    op_q;
  logic [VTX_W-1:0]       a_q, b_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic [HIW-1:0]         hi_q;
  heap_ent_t              hx_q, top_q, cl_q, cr_q;
  logic                   has_r_q;
  logic [VTX_W-1:0]       u_q, wv_q, v_q;
  logic [LEN_W-1:0]       du_q, nd_q, plen_q;
  logic [ENW-1:0]         e_q, enext_q;
  logic [VW:0]            n_q;
  logic [ST_W-1:0]        st_q;
  logic [VTX_W-1:0]       ov_q;
  logic [LEN_W-1:0]       ol_q;
  logic                   olast_q;

  logic [31:0]    w_ext;
  logic [HIW-1:0] hp;
  logic [HIW-1:0] hlast;
  logic [HIW+1:0] hl, hr, hcnt_x;
  logic           sel_l, sel_r;
  heap_ent_t      mv, mval;
  logic [HIW+1:0] midx;
  logic [SW-1:0]  sum;
  logic [LEN_W-1:0] nd;
  logic           out_free, emit;
  logic [ENW-1:0] lh_head;

  assign w_ext    = 32'(in_weight_i);
  assign hp       = (hi_q - HIW'(1)) >> 1;
  assign hlast    = HIW'(hcnt_q - HCW'(1));
  assign hl       = {1'b0, hi_q, 1'b1};
  assign hr       = hl + (HIW + 2)'(1);
  assign hcnt_x   = (HIW + 2)'(hcnt_q);
  assign sel_l    = heap_less(cl_q, hx_q);
  assign mv       = sel_l ? cl_q : hx_q;
  assign sel_r    = has_r_q && heap_less(cr_q, mv);
  assign mval     = sel_r ? cr_q : mv;
  assign midx     = sel_r ? hr : hl;
  assign sum      = SW'(du_q) + SW'(edge_rd_q.wgt);
  assign nd       = (sum > SW'(DIST_MAX)) ? DIST_MAX : sum[LEN_W-1:0];
  assign out_free = !out_vld_q || out_ready_i;
  assign lh_head  = lh_vld_rd_q ? lh_rd_q : E_NULL;
  assign emit     = (cmd_i == CMD_EMIT_OK) || (cmd_i == CMD_EMIT_FULL) ||
                    (cmd_i == CMD_EMIT_NOPATH) || (cmd_i == CMD_EMIT_PATH) ||
                    (cmd_i == CMD_EMIT_SRC);

  always_comb begin
    sts_o.op         = op_q;
    sts_o.add_full   = (ecnt_q == E_NULL);
    sts_o.vtx_ok     = ({1'b0, a_q} < V_LIM) && ({1'b0, b_q} < V_LIM);
    sts_o.heap_empty = (hcnt_q == '0);
    sts_o.heap_full  = (hcnt_q == H_CAP);
    sts_o.su_root    = (hi_q == '0);
    sts_o.su_less    = heap_less(hx_q, heap_rd_q);
    sts_o.sd_leaf    = (hl >= hcnt_x);
    sts_o.sd_has_r   = (hr < hcnt_x);
    sts_o.sd_stay    = !sel_l && !sel_r;
    sts_o.u_settled  = settled_q[top_q.vtx[VW-1:0]];
    sts_o.u_is_t     = (top_q.vtx == b_q);
    sts_o.e_null     = (e_q == E_NULL);
    sts_o.w_skip     = ({1'b0, edge_rd_q.tgt} >= V_LIM) || settled_q[edge_rd_q.tgt[VW-1:0]];
    sts_o.relax_do   = !reached_q[wv_q[VW-1:0]] || (nd_q < dist_rd_q);
    sts_o.t_reached  = reached_q[b_q[VW-1:0]];
    sts_o.path_more  = (v_q != a_q) && ((VW + 1)'(n_q + 1'b1) < N_LIM);
    sts_o.out_free   = out_free;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lh_vld_q  <= '0;
      reached_q <= '0;
      settled_q <= '0;
      ecnt_q    <= '0;
      hcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (cmd_i)
        CMD_ADD_WR: begin
          lh_vld_q[a_q[VW-1:0]] <= 1'b1;
          ecnt_q                <= ecnt_q + ENW'(1);
        end
        CMD_CLEAR: begin
          lh_vld_q <= '0;
          ecnt_q   <= '0;
        end
        CMD_Q_INIT: begin
          reached_q <= NUM_VERTICES'(1) << a_q[VW-1:0];
          settled_q <= '0;
          hcnt_q    <= '0;
        end
        CMD_PUSH: begin
          if (hcnt_q != H_CAP) begin
            hcnt_q <= hcnt_q + HCW'(1);
          end
        end
        CMD_POP_RDL: hcnt_q <= hcnt_q - HCW'(1);
        CMD_SETTLE:  settled_q[top_q.vtx[VW-1:0]] <= 1'b1;
        CMD_E_RELAX: reached_q[wv_q[VW-1:0]] <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers and memories
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        op_q <= op_e'(in_opcode_i);
        a_q  <= in_src_i;
        b_q  <= in_dst_i;
        w_q  <= w_ext[WEIGHT_BITS-1:0];
      end
      CMD_ADD_RD: begin
        lh_rd_q     <= lh_mem[a_q[VW-1:0]];
        lh_vld_rd_q <= lh_vld_q[a_q[VW-1:0]];
      end
      CMD_ADD_WR: begin
        edge_mem[ecnt_q[EIW-1:0]] <= '{tgt: b_q, wgt: w_q, nxt: lh_head};
        lh_mem[a_q[VW-1:0]]       <= ecnt_q;
      end
      CMD_Q_INIT: begin
        dist_mem[a_q[VW-1:0]] <= '0;
        hx_q                  <= '{len: '0, vtx: a_q};
      end
      CMD_PUSH: hi_q <= hcnt_q[HIW-1:0];
      CMD_SU_CHK: begin
        if (hi_q == '0) begin
          heap_mem[hi_q] <= hx_q;
        end else begin
          heap_rd_q <= heap_mem[hp];
        end
      end
      CMD_SU_CMP: begin
        if (heap_less(hx_q, heap_rd_q)) begin
          heap_mem[hi_q] <= heap_rd_q;
          hi_q           <= hp;
        end else begin
          heap_mem[hi_q] <= hx_q;
        end
      end
      CMD_POP_RD0: heap_rd_q <= heap_mem[0];
      CMD_POP_RDL: begin
        top_q     <= heap_rd_q;
        heap_rd_q <= heap_mem[hlast];
      end
      CMD_POP_X: begin
        hx_q <= heap_rd_q;
        hi_q <= '0;
      end
      CMD_SD_CHK: begin
        if (hl >= hcnt_x) begin
          heap_mem[hi_q] <= hx_q;
        end else begin
          heap_rd_q <= heap_mem[hl[HIW-1:0]];
        end
      end
      CMD_SD_L: begin
        cl_q    <= heap_rd_q;
        has_r_q <= (hr < hcnt_x);
        if (hr < hcnt_x) begin
          heap_rd_q <= heap_mem[hr[HIW-1:0]];
        end
      end
      CMD_SD_R: cr_q <= heap_rd_q;
      CMD_SD_CMP: begin
        if (!sel_l && !sel_r) begin
          heap_mem[hi_q] <= hx_q;
        end else begin
          heap_mem[hi_q] <= mval;
          hi_q           <= midx[HIW-1:0];
        end
      end
      CMD_SETTLE: begin
        u_q         <= top_q.vtx;
        du_q        <= top_q.len;
        lh_rd_q     <= lh_mem[top_q.vtx[VW-1:0]];
        lh_vld_rd_q <= lh_vld_q[top_q.vtx[VW-1:0]];
      end
      CMD_E_HEAD: e_q <= lh_head;
      CMD_E_RD:   edge_rd_q <= edge_mem[e_q[EIW-1:0]];
      CMD_E_EVAL: begin
        nd_q      <= nd;
        enext_q   <= edge_rd_q.nxt;
        wv_q      <= edge_rd_q.tgt;
        dist_rd_q <= dist_mem[edge_rd_q.tgt[VW-1:0]];
      end
      CMD_E_RELAX: begin
        dist_mem[wv_q[VW-1:0]] <= nd_q;
        pred_mem[wv_q[VW-1:0]] <= u_q;
        hx_q                   <= '{len: nd_q, vtx: wv_q};
      end
      CMD_E_NEXT:  e_q <= enext_q;
      CMD_FIN_RD:  dist_rd_q <= dist_mem[b_q[VW-1:0]];
      CMD_FIN_LEN: begin
        plen_q <= dist_rd_q;
        v_q    <= b_q;
        n_q    <= '0;
      end
      CMD_EMIT_OK: begin
        st_q <= ST_OK; ov_q <= '0; ol_q <= '0; olast_q <= 1'b1;
      end
      CMD_EMIT_FULL: begin
        st_q <= ST_FULL; ov_q <= '0; ol_q <= '0; olast_q <= 1'b1;
      end
      CMD_EMIT_NOPATH: begin
        st_q <= ST_NOPATH; ov_q <= '0; ol_q <= '0; olast_q <= 1'b1;
      end
      CMD_EMIT_PATH: begin
        st_q      <= ST_OK;
        ov_q      <= v_q;
        ol_q      <= plen_q;
        olast_q   <= 1'b0;
        n_q       <= n_q + 1'b1;
        pred_rd_q <= pred_mem[v_q[VW-1:0]];
      end
      CMD_PATH_NXT: v_q <= pred_rd_q;
      CMD_EMIT_SRC: begin
        st_q <= ST_OK; ov_q <= a_q; ol_q <= plen_q; olast_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_vld_q;
  assign out_status_o = st_q;
  assign out_vertex_o = ov_q;
  assign out_length_o = ol_q;
  assign out_last_o   = olast_q;

  `DSP_ASSERT_NEVER(a_heap_bound, clk_i, rst_ni, hcnt_q > H_CAP, "heap count beyond capacity")
  `DSP_ASSERT_NEVER(a_edge_bound, clk_i, rst_ni, ecnt_q > E_NULL, "edge count beyond store")
  `DSP_ASSERT_NEVER(a_settled_reached, clk_i, rst_ni, (settled_q & ~reached_q) != '0,
                    "settled vertex never reached")
  `DSP_ASSERT(a_src_reached, clk_i, rst_ni, (cmd_i == CMD_Q_INIT) |=> reached_q[a_q[VW-1:0]],
              "source not marked reached")

endmodule

@@ sv/dsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// Shortest path controller
// Sequences edge loads, heap operations, relaxation and path readout.
// ----------------------------------------------------------------------------
module dsp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dsp_pkg::sts_t sts_i,
  output dsp_pkg::cmd_e cmd_o
);
  import dsp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_ADD_RD, S_ADD_WR, S_CLEAR, S_EMIT_OK, S_EMIT_FULL, S_EMIT_NP,
    S_Q_INIT, S_PUSH, S_SU_CHK, S_SU_CMP, S_Q_LOOP, S_POP_RDL, S_POP_X, S_SD_CHK,
    S_SD_L, S_SD_R, S_SD_CMP, S_CHECK, S_SETTLE, S_E_HEAD, S_E_CHK, S_E_EVAL,
    S_E_CMP, S_E_NXT, S_FIN, S_FIN_LEN, S_PATH, S_PATH_NXT
  } state_e;

  state_e state_q, state_d;
  logic   ret_edge_q, ret_edge_d;
  state_e push_ret;

  assign push_ret   = ret_edge_q ? S_E_NXT : S_Q_LOOP;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    ret_edge_d = ret_edge_q;
    cmd_o      = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.op)
          OP_ADD: begin
            if (sts_i.add_full) begin
              state_d = S_EMIT_FULL;
            end else if (sts_i.vtx_ok) begin
              state_d = S_ADD_RD;
            end else begin
              state_d = S_EMIT_OK;
            end
          end
          OP_CLEAR: state_d = S_CLEAR;
          OP_QUERY: state_d = sts_i.vtx_ok ? S_Q_INIT : S_EMIT_NP;
          default:  state_d = S_IDLE;
        endcase
      end
      S_ADD_RD: begin cmd_o = CMD_ADD_RD; state_d = S_ADD_WR; end
      S_ADD_WR: begin cmd_o = CMD_ADD_WR; state_d = S_EMIT_OK; end
      S_CLEAR:  begin cmd_o = CMD_CLEAR;  state_d = S_EMIT_OK; end
      S_EMIT_OK: begin
        if (sts_i.out_free) begin cmd_o = CMD_EMIT_OK; state_d = S_IDLE; end
      end
      S_EMIT_FULL: begin
        if (sts_i.out_free) begin cmd_o = CMD_EMIT_FULL; state_d = S_IDLE; end
      end
      S_EMIT_NP: begin
        if (sts_i.out_free) begin cmd_o = CMD_EMIT_NOPATH; state_d = S_IDLE; end
      end
      S_Q_INIT: begin
        cmd_o      = CMD_Q_INIT;
        ret_edge_d = 1'b0;
        state_d    = S_PUSH;
      end
      S_PUSH: begin
        cmd_o   = CMD_PUSH;
        state_d = sts_i.heap_full ? push_ret : S_SU_CHK;
      end
      S_SU_CHK: begin
        cmd_o   = CMD_SU_CHK;
        state_d = sts_i.su_root ? push_ret : S_SU_CMP;
      end
      S_SU_CMP: begin
        cmd_o   = CMD_SU_CMP;
        state_d = sts_i.su_less ? S_SU_CHK : push_ret;
      end
      S_Q_LOOP: begin
        if (sts_i.heap_empty) begin
          state_d = S_FIN;
        end else begin
          cmd_o   = CMD_POP_RD0;
          state_d = S_POP_RDL;
        end
      end
      S_POP_RDL: begin cmd_o = CMD_POP_RDL; state_d = S_POP_X; end
      S_POP_X:   begin cmd_o = CMD_POP_X;   state_d = S_SD_CHK; end
      S_SD_CHK: begin
        cmd_o   = CMD_SD_CHK;
        state_d = sts_i.sd_leaf ? S_CHECK : S_SD_L;
      end
      S_SD_L: begin
        cmd_o   = CMD_SD_L;
        state_d = sts_i.sd_has_r ? S_SD_R : S_SD_CMP;
      end
      S_SD_R: begin cmd_o = CMD_SD_R; state_d = S_SD_CMP; end
      S_SD_CMP: begin
        cmd_o   = CMD_SD_CMP;
        state_d = sts_i.sd_stay ? S_CHECK : S_SD_CHK;
      end
      S_CHECK: begin
        if (sts_i.u_settled) begin
          state_d = S_Q_LOOP;
        end else if (sts_i.u_is_t) begin
          state_d = S_FIN;
        end else begin
          state_d = S_SETTLE;
        end
      end
      S_SETTLE: begin cmd_o = CMD_SETTLE; state_d = S_E_HEAD; end
      S_E_HEAD: begin cmd_o = CMD_E_HEAD; state_d = S_E_CHK; end
      S_E_CHK: begin
        if (sts_i.e_null) begin
          state_d = S_Q_LOOP;
        end else begin
          cmd_o   = CMD_E_RD;
          state_d = S_E_EVAL;
        end
      end
      S_E_EVAL: begin
        cmd_o   = CMD_E_EVAL;
        state_d = sts_i.w_skip ? S_E_NXT : S_E_CMP;
      end
      S_E_CMP: begin
        if (sts_i.relax_do) begin
          cmd_o      = CMD_E_RELAX;
          ret_edge_d = 1'b1;
          state_d    = S_PUSH;
        end else begin
          cmd_o   = CMD_E_NEXT;
          state_d = S_E_CHK;
        end
      end
      S_E_NXT: begin cmd_o = CMD_E_NEXT; state_d = S_E_CHK; end
      S_FIN: begin
        if (sts_i.t_reached) begin
          cmd_o   = CMD_FIN_RD;
          state_d = S_FIN_LEN;
        end else begin
          state_d = S_EMIT_NP;
        end
      end
      S_FIN_LEN: begin cmd_o = CMD_FIN_LEN; state_d = S_PATH; end
      S_PATH: begin
        if (sts_i.out_free) begin
          if (sts_i.path_more) begin
            cmd_o   = CMD_EMIT_PATH;
            state_d = S_PATH_NXT;
          end else begin
            cmd_o   = CMD_EMIT_SRC;
            state_d = S_IDLE;
          end
        end
      end
      S_PATH_NXT: begin cmd_o = CMD_PATH_NXT; state_d = S_PATH; end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ret_edge_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_edge_q <= ret_edge_d;
    end
  end

endmodule

@@ sv/dijkstra_shortest_path_top.sv @@
// ----------------------------------------------------------------------------
// Shortest path engine, top level
// Edge loading, graph clear and single-pair Dijkstra queries on a min-heap.
// ----------------------------------------------------------------------------
// One command beat is taken at a time. Add edge and clear each answer the
// accepted beat with a single result beat. A query pops the heap and sifts
// down, scans each edge of a newly settled vertex, relaxes and pushes with a
// sift-up where the edge gives a shorter distance, and then emits path beats;
// the heap memory is single-port, read one entry a cycle. Path beats run from
// target back to source, all carrying the total distance, with last on the
// source beat. No clearing pass follows reset.
module dijkstra_shortest_path_top #(
  parameter int unsigned NUM_VERTICES = dsp_pkg::NUM_VERTICES_DEF,
  parameter int unsigned NUM_EDGES    = dsp_pkg::NUM_EDGES_DEF,
  parameter int unsigned WEIGHT_BITS  = dsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsp_in_if.sink    in_i,
  dsp_out_if.source out_o
);
  import dsp_pkg::*;

  cmd_e cmd;
  sts_t sts;

  dsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dsp_datapath #(
    .NUM_VERTICES (NUM_VERTICES),
    .NUM_EDGES    (NUM_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_opcode_i  (in_i.opcode),
    .in_src_i     (in_i.src_vertex),
    .in_dst_i     (in_i.dst_vertex),
    .in_weight_i  (in_i.weight),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_status_o (out_o.status),
    .out_vertex_o (out_o.path_vertex),
    .out_length_o (out_o.path_length),
    .out_last_o   (out_o.last)
  );

endmodule

@@ sim/dijkstra_shortest_path_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest path engine testbench
// Drives add, clear and query beats through the input channel, predicts every
// result beat with an in-bench Dijkstra search and compares the result stream
// in order, under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module dijkstra_shortest_path_top_test;
  import dsp_pkg::*;

  localparam int unsigned NV        = NUM_VERTICES_DEF;
  localparam int unsigned NE        = NUM_EDGES_DEF;
  localparam int unsigned WD_LIMIT  = 200000;
  localparam int unsigned END_WAIT  = 64;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [VTX_W-1:0] vertex;
    logic [LEN_W-1:0] length;
    logic             last;
  } path_beat_t;

  logic clk_i;
  logic rst_ni;

  dsp_in_if  in_bus ();
  dsp_out_if out_bus ();

  dijkstra_shortest_path_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  path_beat_t  expected_beats[$];
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;

  int unsigned graph_head[NV];
  int unsigned graph_target[NE];
  int unsigned graph_weight[NE];
  int unsigned graph_next[NE];
  int unsigned graph_edges;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic push_beat(logic [ST_W-1:0] st, logic [VTX_W-1:0] v,
                           logic [LEN_W-1:0] len, logic lst);
    path_beat_t b;
    b.status = st;
    b.vertex = v;
    b.length = len;
    b.last   = lst;
    expected_beats.push_back(b);
  endtask

  task automatic graph_clear();
    for (int i = 0; i < NV; i++) graph_head[i] = NE;
    graph_edges = 0;
  endtask

  task automatic predict_shortest_path(int unsigned s, int unsigned t);
    int unsigned best_len[NV];
    bit          reached[NV];
    bit          settled[NV];
    int unsigned pred[NV];
    int unsigned u, w, nd, v, n;
    bit          found;
    for (int i = 0; i < NV; i++) begin
      reached[i]  = 0;
      settled[i]  = 0;
      best_len[i] = 0;
      pred[i]     = 0;
    end
    best_len[s] = 0;
    reached[s]  = 1;
    forever begin
      found = 0;
      u = 0;
      for (int i = 0; i < NV; i++) begin
        if (reached[i] && !settled[i] && (!found || best_len[i] < best_len[u])) begin
          u = i;
          found = 1;
        end
      end
      if (!found || u == t) break;
      settled[u] = 1;
      for (int e = graph_head[u]; e < NE; e = graph_next[e]) begin
        w  = graph_target[e];
        nd = best_len[u] + graph_weight[e];
        if (nd > DIST_MAX) nd = DIST_MAX;
        if (settled[w]) continue;
        if (!reached[w] || nd < best_len[w]) begin
          best_len[w] = nd;
          reached[w]  = 1;
          pred[w]     = u;
        end
      end
    end
    if (!reached[t]) begin
      push_beat(ST_NOPATH, '0, '0, 1'b1);
    end else begin
      v = t;
      n = 0;
      while (v != s && n + 1 < NV) begin
        push_beat(ST_OK, v[VTX_W-1:0], best_len[t][LEN_W-1:0], 1'b0);
        n++;
        v = pred[v];
      end
      push_beat(ST_OK, s[VTX_W-1:0], best_len[t][LEN_W-1:0], 1'b1);
    end
  endtask

  task automatic predict_command(op_e op, int unsigned a, int unsigned b, int unsigned w);
    case (op)
      OP_ADD: begin
        if (graph_edges >= NE) begin
          push_beat(ST_FULL, '0, '0, 1'b1);
        end else begin
          graph_target[graph_edges] = b;
          graph_weight[graph_edges] = w;
          graph_next[graph_edges]   = graph_head[a];
          graph_head[a]             = graph_edges;
          graph_edges++;
          push_beat(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_CLEAR: begin
        graph_clear();
        push_beat(ST_OK, '0, '0, 1'b1);
      end
      OP_QUERY: predict_shortest_path(a, b);
      default: ;
    endcase
  endtask

  task automatic send_command(op_e op, int unsigned a, int unsigned b, int unsigned w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= op;
    in_bus.src_vertex <= a[VTX_W-1:0];
    in_bus.dst_vertex <= b[VTX_W-1:0];
    in_bus.weight     <= w[WIN_W-1:0];
    do @(posedge clk_i); while (!in_bus.ready);
    predict_command(op, a & ((1 << VTX_W) - 1), b & ((1 << VTX_W) - 1),
                    w & ((1 << WIN_W) - 1));
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    path_beat_t b;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat, status", out_bus.status, 0);
      end else begin
        b = expected_beats.pop_front();
        if (out_bus.status !== b.status) report_mismatch("status", out_bus.status, b.status);
        if (out_bus.path_vertex !== b.vertex)
          report_mismatch("path_vertex", out_bus.path_vertex, b.vertex);
        if (out_bus.path_length !== b.length)
          report_mismatch("path_length", out_bus.path_length, b.length);
        if (out_bus.last !== b.last) report_mismatch("last", out_bus.last, b.last);
      end
    end
  end

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WD_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic test_add_and_clear();
    send_command(OP_ADD, 0, 63, 16'hFFFF);
    send_command(OP_ADD, 63, 0, 0);
    send_command(OP_ADD, 21, 42, 16'h5555);
    send_command(OP_ADD, 42, 21, 16'hAAAA);
    send_command(OP_QUERY, 0, 63, 0);
    send_command(OP_CLEAR, 0, 0, 0);
    send_command(OP_QUERY, 0, 63, 0);
  endtask

  task automatic test_directed_queries();
    send_command(OP_ADD, 0, 1, 5);
    send_command(OP_ADD, 0, 2, 3);
    send_command(OP_ADD, 2, 1, 2);
    send_command(OP_ADD, 1, 3, 1);
    send_command(OP_ADD, 2, 3, 3);
    send_command(OP_ADD, 3, 3, 7);
    send_command(OP_QUERY, 0, 1, 0);
    send_command(OP_QUERY, 0, 3, 0);
    send_command(OP_QUERY, 1, 0, 0);
    send_command(OP_QUERY, 5, 5, 0);
    send_command(OP_QUERY, 63, 63, 16'hFFFF);
    send_command(OP_NONE, 63, 63, 16'hFFFF);
    send_command(OP_NONE, 0, 0, 0);
    send_command(OP_CLEAR, 63, 63, 16'hFFFF);
  endtask

  task automatic test_long_chain();
    for (int i = 0; i < NV - 1; i++) send_command(OP_ADD, i, i + 1, 16'hFFFF);
    send_command(OP_QUERY, 0, NV - 1, 0);
    send_command(OP_QUERY, NV - 1, 0, 0);
    send_command(OP_CLEAR, 0, 0, 0);
  endtask

  task automatic test_random_graphs(int unsigned idle, int unsigned stall, int unsigned items);
    int unsigned sent, base, span, nedge;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      base  = $urandom_range(NV - 8);
      span  = $urandom_range(3, 7);
      nedge = $urandom_range(4, 14);
      send_command(OP_CLEAR, $urandom, $urandom, $urandom);
      sent++;
      for (int i = 0; i < nedge; i++) begin
        send_command(OP_ADD, base + $urandom_range(span), base + $urandom_range(span),
                     ($urandom_range(3) == 0) ? $urandom : $urandom_range(20));
        sent++;
      end
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(9))
          0: send_command(OP_NONE, $urandom, $urandom, $urandom);
          1: send_command(OP_QUERY, $urandom, $urandom, $urandom);
          2: send_command(OP_ADD, $urandom, $urandom, $urandom);
          default: send_command(OP_QUERY, base + $urandom_range(span),
                                base + $urandom_range(span), $urandom);
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    graph_clear();
    in_bus.valid      <= 1'b0;
    in_bus.opcode     <= OP_NONE;
    in_bus.src_vertex <= '0;
    in_bus.dst_vertex <= '0;
    in_bus.weight     <= '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_add_and_clear();
    wait_drained();
    test_directed_queries();
    test_long_chain();
    test_random_graphs(0, 0, 12);
    test_random_graphs(70, 0, 12);
    wait_drained();
    test_random_graphs(0, 70, 12);
    test_random_graphs(37, 37, 12);

    wait_drained();
    repeat (END_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
